/* rtl/distinct_value_counter_top_assert.svh */
// ----------------------------------------------------------------------------
// distinct value counter assertion macros
// property wrappers that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef DISTINCT_VALUE_COUNTER_TOP_ASSERT_SVH
`define DISTINCT_VALUE_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DVC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dvc: same-cycle implication failed");

// next-cycle implication
`define DVC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dvc: next-cycle implication failed");

`else

`define DVC_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define DVC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/dvc_pkg.sv */
// ----------------------------------------------------------------------------
// dvc_pkg
// shared types and constants of the distinct value counter
// ----------------------------------------------------------------------------
`default_nettype none

package dvc_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned SLOT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // sample travelling down the chain
    typedef struct packed {
        logic               valid;
        logic               eos;
        logic               hit;
        logic [VALUE_W-1:0] value;
    } item_t;

    // contents of one table slot
    typedef struct packed {
        logic               occ;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } slot_t;

endpackage

`default_nettype wire

/* rtl/dvc_cell.sv */
// ----------------------------------------------------------------------------
// dvc_cell
// one table slot: matches or claims a passing sample, shifts back on drain
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dvc_pkg::item_t item_i,
    output dvc_pkg::item_t     item_o,
    input  wire logic          shift_en,
    input  wire dvc_pkg::slot_t slot_i,
    output dvc_pkg::slot_t     slot_o
);

    dvc_pkg::item_t item_reg;
    dvc_pkg::item_t item_next;
    dvc_pkg::slot_t slot_reg;
    dvc_pkg::slot_t slot_next;
    logic           live;
    logic           match;
    logic           claim;

    assign live  = item_i.valid && !item_i.hit;
    assign match = live && slot_reg.occ && (slot_reg.value == item_i.value);
    assign claim = live && !slot_reg.occ;

    always_comb begin
        slot_next = slot_reg;
        if (shift_en) begin
            slot_next = slot_i;
        end else if (claim) begin
            slot_next.occ   = 1'b1;
            slot_next.value = item_i.value;
            slot_next.count = {{(dvc_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end else if (match && (slot_reg.count != dvc_pkg::COUNT_MAX)) begin
            slot_next.count = slot_reg.count + {{(dvc_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_comb begin
        item_next     = item_i;
        item_next.hit = item_i.hit | match | claim;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
            slot_reg.occ   <= 1'b0;
        end else begin
            item_reg <= item_next;
            slot_reg <= slot_next;
        end
    end

    assign item_o = item_reg;
    assign slot_o = slot_reg;

endmodule

`default_nettype wire

/* rtl/distinct_value_counter_top.sv */
// ----------------------------------------------------------------------------
// distinct_value_counter_top
// histogram of distinct sample values held in a chain of slot cells
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready  | sample value, end of sequence mark
//  m_      | out | m_valid / m_ready  | value, count, slot, final, overflow flag
//
//  samples are taken one per cycle while s_ready is high; each walks the chain
//  one cell per cycle and is counted in the slot that holds its value or claims
//  the first free one; after an end-of-sequence beat the input stalls while that
//  beat reaches the chain end, then while the chain shifts back toward cell 0 one
//  entry at a time, until cell 0 is seen empty
//  m_ready low freezes the drain; aresetn empties every slot at once
//
`default_nettype none

module distinct_value_counter_top #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // sample beats
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [dvc_pkg::VALUE_W-1:0]    s_sample_value,
    input  wire logic                                  s_end_of_sequence,
    // table entry beats
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [dvc_pkg::VALUE_W-1:0]         m_entry_value,
    output logic        [dvc_pkg::COUNT_W-1:0]         m_entry_count,
    output logic        [dvc_pkg::SLOT_W-1:0]          m_entry_slot,
    output logic                                       m_final_entry,
    output logic                                       m_table_overflowed
);

`include "distinct_value_counter_top_assert.svh"

    // absorb: taking samples; flush: end beat still walking; drain: emitting
    typedef enum logic [2:0] {
        ST_ABSORB = 3'b001,
        ST_FLUSH  = 3'b010,
        ST_DRAIN  = 3'b100
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;

    // item_chain[k] feeds cell k; item_chain[TABLE_DEPTH] leaves the last cell
    dvc_pkg::item_t               item_chain [TABLE_DEPTH+1];
    // slot_chain[k] is cell k's slot; the one past the end reads as empty
    dvc_pkg::slot_t               slot_chain [TABLE_DEPTH+1];

    logic [TABLE_DEPTH-1:0]       occ_vec;
    logic [TABLE_DEPTH-1:0]       occ_inc;
    logic [TABLE_DEPTH-1:0]       item_vld_vec;

    logic                         ovf_reg;
    logic                         ovf_next;
    logic [dvc_pkg::SLOT_W-1:0]   slot_cnt_reg;
    logic [dvc_pkg::SLOT_W-1:0]   slot_cnt_next;

    logic                         m_valid_reg;
    logic [dvc_pkg::VALUE_W-1:0]  m_value_reg;
    logic [dvc_pkg::COUNT_W-1:0]  m_count_reg;
    logic [dvc_pkg::SLOT_W-1:0]   m_slot_reg;
    logic                         m_final_reg;
    logic                         m_ovf_reg;

    logic                         in_fire;
    logic                         emit_load;
    logic                         tail_drop;
    logic                         tail_eos;

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_ABSORB);
    assign in_fire = s_valid && s_ready;

    assign item_chain[0] = '{valid: in_fire, eos: s_end_of_sequence, hit: 1'b0,
                             value: s_sample_value};

    assign slot_chain[TABLE_DEPTH] = '0;

    // ------------------------------------------------------------------
    // the chain of slot cells
    // ------------------------------------------------------------------
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        dvc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .item_i   (item_chain[k]),
            .item_o   (item_chain[k+1]),
            .shift_en (emit_load),
            .slot_i   (slot_chain[k+1]),
            .slot_o   (slot_chain[k])
        );
        assign occ_vec[k]      = slot_chain[k].occ;
        assign item_vld_vec[k] = item_chain[k+1].valid;
    end

    // a sample that falls off the end unclaimed found the table full
    assign tail_drop = item_chain[TABLE_DEPTH].valid && !item_chain[TABLE_DEPTH].hit;
    assign tail_eos  = item_chain[TABLE_DEPTH].valid && item_chain[TABLE_DEPTH].eos;

    // ------------------------------------------------------------------
    // drain: cell 0 moves to the output register, the chain shifts back
    // ------------------------------------------------------------------
    assign emit_load = (state_reg == ST_DRAIN) && slot_chain[0].occ
                       && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        ovf_next      = ovf_reg | tail_drop;
        slot_cnt_next = slot_cnt_reg;
        case (state_reg)
            ST_ABSORB: begin
                if (in_fire && s_end_of_sequence) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (tail_eos) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (emit_load) begin
                    slot_cnt_next = slot_cnt_reg + {{(dvc_pkg::SLOT_W-1){1'b0}}, 1'b1};
                end
                // table emptied: start a new run
                if (!slot_chain[0].occ) begin
                    state_next    = ST_ABSORB;
                    ovf_next      = 1'b0;
                    slot_cnt_next = '0;
                end
            end
            default: begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ABSORB;
            ovf_reg      <= 1'b0;
            slot_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            ovf_reg      <= ovf_next;
            slot_cnt_reg <= slot_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_value_reg <= slot_chain[0].value;
            m_count_reg <= slot_chain[0].count;
            m_slot_reg  <= slot_cnt_reg;
            // last occupied slot when its right neighbor is empty
            m_final_reg <= !slot_chain[1].occ;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_entry_value      = m_value_reg;
    assign m_entry_count      = m_count_reg;
    assign m_entry_slot       = m_slot_reg;
    assign m_final_entry      = m_final_reg;
    assign m_table_overflowed = m_ovf_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    assign occ_inc = occ_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1};

    // occupied slots always form an unbroken prefix of the chain
    `DVC_ASSERT_IMPLY(a_occ_prefix, aclk, aresetn, 1'b1, (occ_vec & occ_inc) == '0)
    // no sample is in flight while the table drains
    `DVC_ASSERT_IMPLY(a_drain_chain_empty, aclk, aresetn, state_reg == ST_DRAIN,
                      item_vld_vec == '0)
    // nothing follows the final entry of a run straight away
    `DVC_ASSERT_NEXT(a_final_then_idle, aclk, aresetn,
                     m_valid && m_ready && m_final_entry, !m_valid)

endmodule

`default_nettype wire

/* tb/tb_distinct_value_counter_top.sv */
// ----------------------------------------------------------------------------
// tb_distinct_value_counter_top
// drives sample beats into the distinct value counter and checks every table
// entry beat against a software tally of value, count, slot, final and drop flag
// ----------------------------------------------------------------------------
`default_nettype none

module tb_distinct_value_counter_top;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned CLK_HALF    = 6;
    localparam int unsigned TOTAL_ITEMS = 270;
    localparam int unsigned MAX_REPORTS = 10;

    // one expected table entry beat
    typedef struct packed {
        logic [dvc_pkg::VALUE_W-1:0] value;
        logic [dvc_pkg::COUNT_W-1:0] count;
        logic [dvc_pkg::SLOT_W-1:0]  slot;
        logic                        last;
        logic                        dropped;
    } entry_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [dvc_pkg::VALUE_W-1:0]  s_sample_value = '0;
    logic                                s_end_of_sequence = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [dvc_pkg::VALUE_W-1:0]  m_entry_value;
    logic        [dvc_pkg::COUNT_W-1:0]  m_entry_count;
    logic        [dvc_pkg::SLOT_W-1:0]   m_entry_slot;
    logic                                m_final_entry;
    logic                                m_table_overflowed;

    // tally of the current sequence, kept alongside the block
    logic [dvc_pkg::VALUE_W-1:0] tally_value [DEPTH];
    logic [dvc_pkg::COUNT_W-1:0] tally_count [DEPTH];
    int unsigned                 tally_fill;
    logic                        tally_dropped;

    entry_t      pending_entries[$];
    int unsigned mismatches;
    bit          steady_flow;   // both sides run without gaps while set
    int unsigned samples_sent;

    distinct_value_counter_top #(
        .TABLE_DEPTH        (DEPTH)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_value     (s_sample_value),
        .s_end_of_sequence  (s_end_of_sequence),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_entry_value      (m_entry_value),
        .m_entry_count      (m_entry_count),
        .m_entry_slot       (m_entry_slot),
        .m_final_entry      (m_final_entry),
        .m_table_overflowed (m_table_overflowed)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // count one sample; on end of sequence queue every occupied slot and clear
    task automatic tally_sample(input logic [dvc_pkg::VALUE_W-1:0] v, input logic eos);
        bit     found;
        entry_t e;
        found = 1'b0;
        for (int unsigned k = 0; k < tally_fill; k++) begin
            if (!found && tally_value[k] == v) begin
                found = 1'b1;
                // counts stick at the top value
                if (tally_count[k] != dvc_pkg::COUNT_MAX)
                    tally_count[k] = tally_count[k] + 1'b1;
            end
        end
        if (!found) begin
            if (tally_fill < DEPTH) begin
                tally_value[tally_fill] = v;
                tally_count[tally_fill] = 24'd1;
                tally_fill++;
            end else begin
                // table full: new value lost, flag sticks until the drain
                tally_dropped = 1'b1;
            end
        end
        if (eos) begin
            for (int unsigned k = 0; k < tally_fill; k++) begin
                e.value   = tally_value[k];
                e.count   = tally_count[k];
                e.slot    = k[dvc_pkg::SLOT_W-1:0];
                e.last    = (k + 1 == tally_fill);
                e.dropped = tally_dropped;
                pending_entries.push_back(e);
            end
            tally_fill    = 0;
            tally_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------------

    // present one sample beat and return at the edge that accepts it;
    // valid is left high so the next beat can follow back to back
    task automatic send_sample(input logic [dvc_pkg::VALUE_W-1:0] v, input logic eos);
        while (!steady_flow && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_sample_value    <= v;
        s_end_of_sequence <= eos;
        tally_sample(v, eos);
        samples_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and hold off until every queued entry beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_entries.size() != 0) @(posedge aclk);
    endtask

    // mix of full-range patterns, small signed numbers and the extremes
    function automatic logic [dvc_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: pick_value = $urandom();
            1: pick_value = $urandom_range(0, 8) - 4;
            2: pick_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: pick_value = 32'h1 << $urandom_range(0, 31);
            default: pick_value = ~$urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // entry side: random back-pressure and the checker
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what,
                                 input logic [dvc_pkg::VALUE_W-1:0] want,
                                 input logic [dvc_pkg::VALUE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("tb: %s mismatch, expected %h, got %h", what, want, got);
    endtask

    always @(posedge aclk) begin
        entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_entries.size() == 0) begin
                note_mismatch("unexpected entry beat, value", '0, m_entry_value);
            end else begin
                want = pending_entries.pop_front();
                if (m_entry_value !== want.value)
                    note_mismatch("entry_value", want.value, m_entry_value);
                if (m_entry_count !== want.count)
                    note_mismatch("entry_count", 32'(want.count), 32'(m_entry_count));
                if (m_entry_slot !== want.slot)
                    note_mismatch("entry_slot", 32'(want.slot), 32'(m_entry_slot));
                if (m_final_entry !== want.last)
                    note_mismatch("final_entry", 32'(want.last), 32'(m_final_entry));
                if (m_table_overflowed !== want.dropped)
                    note_mismatch("table_overflowed", 32'(want.dropped),
                                  32'(m_table_overflowed));
            end
        end
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 20);
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // extremes, sign patterns and a value seen many times
    task automatic test_extremes();
        logic [dvc_pkg::VALUE_W-1:0] edge_vals [14];
        edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFF,
                      32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
                      32'hAAAA_AAAA, 32'hFFFF_FFFF};
        // a sequence of one sample
        send_sample(32'h8000_0000, 1'b1);
        // most negative and most positive, alternating bits, near neighbors
        foreach (edge_vals[i])
            send_sample(edge_vals[i], i == 13);
        // one value only, counted three times
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b1);
    endtask

    // exactly fills the table: the end-of-sequence beat takes the last slot
    task automatic test_full_table();
        logic [dvc_pkg::VALUE_W-1:0] base;
        for (int unsigned k = 0; k < DEPTH; k++) begin
            base = $urandom();
            send_sample({base[dvc_pkg::VALUE_W-1:7], k[6:0]}, k == DEPTH - 1);
        end
    endtask

    // new values past a full table are dropped, known ones still counted;
    // the flag must be gone again on the next sequence
    task automatic test_overflow();
        logic [dvc_pkg::VALUE_W-1:0] known [DEPTH];
        logic [dvc_pkg::VALUE_W-1:0] base;
        for (int unsigned k = 0; k < DEPTH; k++) begin
            base = $urandom();
            known[k] = {base[dvc_pkg::VALUE_W-1:7], k[6:0]};
            send_sample(known[k], 1'b0);
        end
        for (int unsigned k = 0; k < 4; k++) begin
            base = $urandom();
            send_sample({base[dvc_pkg::VALUE_W-1:7], 7'h40 + k[6:0]}, 1'b0);
        end
        send_sample(known[0], 1'b0);
        send_sample(known[DEPTH-1], 1'b0);
        send_sample(known[0], 1'b0);
        // end-of-sequence beat itself is a dropped value
        send_sample({known[5][dvc_pkg::VALUE_W-1:7], 7'h7F}, 1'b1);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'h1234_5678, 1'b1);
    endtask

    // sender stops until all entries are out, then carries on
    task automatic test_drain_pause();
        send_sample(32'hDEAD_BEEF, 1'b0);
        send_sample(32'h0000_0007, 1'b0);
        send_sample(32'hDEAD_BEEF, 1'b1);
        wait_drained();
        send_sample(32'h0000_0007, 1'b1);
    endtask

    // well-formed sequences with random content up to the total item budget;
    // values come from a small pool so repeats are common, and now and then a
    // wide sequence spills past the table
    task automatic test_random_sequences();
        logic [dvc_pkg::VALUE_W-1:0] pool[$];
        logic [dvc_pkg::VALUE_W-1:0] base;
        logic [dvc_pkg::VALUE_W-1:0] v;
        int unsigned                 seq_len;
        int unsigned                 pool_size;
        bit                          wide;
        while (samples_sent < TOTAL_ITEMS) begin
            wide = ($urandom_range(0, 9) == 0);
            pool.delete();
            if (wide) begin
                seq_len = $urandom_range(60, 90);
                for (int unsigned k = 0; k < 72; k++) begin
                    base = $urandom();
                    pool.push_back({base[dvc_pkg::VALUE_W-1:7], k[6:0]});
                end
            end else begin
                seq_len   = $urandom_range(1, 24);
                pool_size = $urandom_range(1, 12);
                for (int unsigned k = 0; k < pool_size; k++)
                    pool.push_back(pick_value());
            end
            if (seq_len > TOTAL_ITEMS - samples_sent)
                seq_len = TOTAL_ITEMS - samples_sent;
            for (int unsigned n = 0; n < seq_len; n++) begin
                if (!wide && $urandom_range(0, 9) == 0)
                    v = pick_value();
                else
                    v = pool[$urandom_range(0, pool.size() - 1)];
                send_sample(v, n == seq_len - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        mismatches    = 0;
        samples_sent  = 0;
        tally_fill    = 0;
        tally_dropped = 1'b0;
        steady_flow   = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_full_table();
        // long stretch with no gaps on either side
        steady_flow = 1'b1;
        test_overflow();
        steady_flow = 1'b0;
        test_drain_pause();
        test_random_sequences();

        // let the last drain finish, then give the block time to show
        // anything extra
        wait_drained();
        repeat (3 * DEPTH) @(posedge aclk);

        if (mismatches == 0 && pending_entries.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 400000);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
